@@ hdl/spa_pkg.sv @@
// shared types and constants for the sparse polynomial adder
// no dependencies; imported by every module of the block
`default_nettype none

package spa_pkg;

	localparam int MAX_TERMS = 32;
	localparam int ADDR_W    = 5;
	localparam int CNT_W     = 6;
	localparam int COEF_W    = 16;
	localparam int SUM_W     = 17;
	localparam int EXP_W     = 10;

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_RUN    = 2'd2;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic [EXP_W-1:0]         expon;
	} term_t;

	// handoff from the load side to the merge sequencer
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] cnt_a;
		logic [CNT_W-1:0] cnt_b;
		logic             lost;
	} run_req_t;

endpackage

`default_nettype wire

@@ hdl/spa_term_mem.sv @@
// term buffer: one write port, one read port, registered read data
// depends on spa_pkg
`default_nettype none

module spa_term_mem
	import spa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire term_t             wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output term_t                  rdata
);

	term_t mem [MAX_TERMS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/spa_merge.sv @@
// merge sequencer: walks both buffers, holds one term back to mark the last,
// and drives the output register; depends on spa_pkg
`default_nettype none

module spa_merge
	import spa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire run_req_t          req,
	input  wire term_t             head_a,
	input  wire term_t             head_b,
	output logic [ADDR_W-1:0]      raddr_a,
	output logic [ADDR_W-1:0]      raddr_b,
	output logic                   busy,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [SUM_W-1:0] sum_coef,
	output logic [EXP_W-1:0]       sum_expon,
	output logic                   final_term,
	output logic                   no_terms,
	output logic                   lost_load
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_MERGE = 1'b1;

	logic                    state_q;
	logic [CNT_W-1:0]        idx_a_q, idx_b_q, idx_a_d, idx_b_d;
	logic [CNT_W-1:0]        na_q, nb_q;
	logic                    lost_q;
	logic                    pend_v_q;
	logic signed [SUM_W-1:0] pend_coef_q;
	logic [EXP_W-1:0]        pend_expon_q;

	logic                    have_a, have_b, done, step, out_free;
	logic                    take_a, take_b, emit, push;
	logic signed [SUM_W-1:0] coef_a, coef_b, new_coef;
	logic [EXP_W-1:0]        new_expon;

	assign out_free = !out_valid || out_ready;
	assign have_a   = idx_a_q < na_q;
	assign have_b   = idx_b_q < nb_q;
	assign done     = !have_a && !have_b;
	assign step     = (state_q == ST_MERGE) && out_free;
	assign coef_a   = SUM_W'(head_a.coef);
	assign coef_b   = SUM_W'(head_b.coef);
	assign busy     = (state_q == ST_MERGE);

	always_comb begin
		take_a    = 1'b0;
		take_b    = 1'b0;
		emit      = 1'b0;
		new_coef  = coef_a;
		new_expon = head_a.expon;
		priority if (have_a && have_b) begin
			if (head_a.expon == head_b.expon) begin
				take_a   = 1'b1;
				take_b   = 1'b1;
				new_coef = coef_a + coef_b;
				// a zero sum cancels out of the result
				emit     = (new_coef != '0);
			end else if (head_a.expon > head_b.expon) begin
				take_a = 1'b1;
				emit   = 1'b1;
			end else begin
				take_b    = 1'b1;
				emit      = 1'b1;
				new_coef  = coef_b;
				new_expon = head_b.expon;
			end
		end else if (have_a) begin
			take_a = 1'b1;
			emit   = 1'b1;
		end else if (have_b) begin
			take_b    = 1'b1;
			emit      = 1'b1;
			new_coef  = coef_b;
			new_expon = head_b.expon;
		end else begin
			emit = 1'b0;
		end
	end

	// read address leads the index so the registered head matches it
	always_comb begin
		if (state_q == ST_IDLE || (step && done)) begin
			idx_a_d = '0;
			idx_b_d = '0;
		end else begin
			idx_a_d = idx_a_q + CNT_W'(step && take_a);
			idx_b_d = idx_b_q + CNT_W'(step && take_b);
		end
	end

	assign raddr_a = idx_a_d[ADDR_W-1:0];
	assign raddr_b = idx_b_d[ADDR_W-1:0];

	// the held term moves out when a newer one arrives or the walk ends
	assign push = step && ((emit && pend_v_q) || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_a_q   <= '0;
			idx_b_q   <= '0;
			na_q      <= '0;
			nb_q      <= '0;
			lost_q    <= 1'b0;
			pend_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			idx_a_q <= idx_a_d;
			idx_b_q <= idx_b_d;
			if (push) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_MERGE;
						na_q    <= req.cnt_a;
						nb_q    <= req.cnt_b;
						lost_q  <= req.lost;
					end
				end
				ST_MERGE: begin
					if (step) begin
						if (done) begin
							state_q  <= ST_IDLE;
							pend_v_q <= 1'b0;
						end else if (emit) begin
							pend_v_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			pend_coef_q  <= new_coef;
			pend_expon_q <= new_expon;
		end
		if (push) begin
			lost_load <= lost_q;
			if (done) begin
				final_term <= 1'b1;
				no_terms   <= !pend_v_q;
				sum_coef   <= pend_v_q ? pend_coef_q : '0;
				sum_expon  <= pend_v_q ? pend_expon_q : '0;
			end else begin
				final_term <= 1'b0;
				no_terms   <= 1'b0;
				sum_coef   <= pend_coef_q;
				sum_expon  <= pend_expon_q;
			end
		end
	end

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("held term left over outside a run");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (idx_a_q <= na_q && idx_b_q <= nb_q))
		else $error("merge index ran past its buffer count");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && out_valid && !out_ready) |=>
			($stable(idx_a_q) && $stable(idx_b_q)))
		else $error("merge advanced while output stalled");

	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && step && done) |=> (out_valid && final_term))
		else $error("end of run without a final beat");

endmodule

`default_nettype wire

@@ hdl/sparse_polynomial_add.sv @@
// no input beat is taken while a merge runs; each result passes the held-term
// register, then the output register (an empty sum goes straight there)
// throughput: load beats one per cycle; results at most one per cycle while
// out_ready allows, set by the single read port per buffer
// reset: arst_n clears counts, overflow flag and sequencer; buffers keep
// whatever they held, and only entries written since the last run are read
// top level: load control, two term buffers, merge sequencer
// depends on spa_pkg, spa_term_mem, spa_merge
`default_nettype none

module sparse_polynomial_add
	import spa_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          op,
	input  wire logic signed [COEF_W-1:0] term_coef,
	input  wire logic [EXP_W-1:0]    term_expon,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [SUM_W-1:0]  sum_coef,
	output logic [EXP_W-1:0]         sum_expon,
	output logic                     final_term,
	output logic                     no_terms,
	output logic                     lost_load
);

	logic [CNT_W-1:0]  cnt_a_q, cnt_b_q;
	logic              dropped_q;
	logic              busy, acc, load_a, load_b, room_a, room_b;
	logic [ADDR_W-1:0] raddr_a, raddr_b;
	term_t             wterm, head_a, head_b;
	run_req_t          req;

	assign in_ready = !busy;
	assign acc      = in_valid && in_ready;
	assign room_a   = cnt_a_q < CNT_W'(MAX_TERMS);
	assign room_b   = cnt_b_q < CNT_W'(MAX_TERMS);
	assign load_a   = acc && (op == OP_LOAD_A) && room_a;
	assign load_b   = acc && (op == OP_LOAD_B) && room_b;
	assign wterm    = '{coef: term_coef, expon: term_expon};

	assign req.start = acc && (op == OP_RUN);
	assign req.cnt_a = cnt_a_q;
	assign req.cnt_b = cnt_b_q;
	assign req.lost  = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (req.start) begin
				cnt_a_q   <= '0;
				cnt_b_q   <= '0;
				dropped_q <= 1'b0;
			end else begin
				if (load_a) begin
					cnt_a_q <= cnt_a_q + CNT_W'(1);
				end
				if (load_b) begin
					cnt_b_q <= cnt_b_q + CNT_W'(1);
				end
				// full buffer: the beat is dropped and remembered
				if (acc && ((op == OP_LOAD_A && !room_a) || (op == OP_LOAD_B && !room_b))) begin
					dropped_q <= 1'b1;
				end
			end
		end
	end

	spa_term_mem u_mem_a (
		.clk   (clk),
		.we    (load_a),
		.waddr (cnt_a_q[ADDR_W-1:0]),
		.wdata (wterm),
		.raddr (raddr_a),
		.rdata (head_a)
	);

	spa_term_mem u_mem_b (
		.clk   (clk),
		.we    (load_b),
		.waddr (cnt_b_q[ADDR_W-1:0]),
		.wdata (wterm),
		.raddr (raddr_b),
		.rdata (head_b)
	);

	spa_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.head_a     (head_a),
		.head_b     (head_b),
		.raddr_a    (raddr_a),
		.raddr_b    (raddr_b),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sum_coef   (sum_coef),
		.sum_expon  (sum_expon),
		.final_term (final_term),
		.no_terms   (no_terms),
		.lost_load  (lost_load)
	);

endmodule

`default_nettype wire

@@ tb/sparse_polynomial_add_tb.sv @@
// self-checking testbench for sparse_polynomial_add: random load/run traffic with
// a merge predictor and in-order result scoreboard; depends on spa_pkg and the block
`timescale 1ns / 1ps

module sparse_polynomial_add_tb;
	import spa_pkg::*;

	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0] op;
		term_t      t;
	} beat_t;

	typedef struct {
		logic signed [SUM_W-1:0] coef;
		logic [EXP_W-1:0]        expon;
		logic                    final_flag;
		logic                    empty_flag;
		logic                    lost_flag;
	} sum_term_t;

	typedef enum int {SEQ_NORMAL, SEQ_LARGE, SEQ_OVERFLOW, SEQ_NOISE} seq_kind_t;

	class poly_sum_board;
		term_t first_buf[MAX_TERMS];
		term_t second_buf[MAX_TERMS];
		int first_cnt;
		int second_cnt;
		bit lost;
		sum_term_t sums[$];

		function void clear();
			first_cnt = 0;
			second_cnt = 0;
			lost = 0;
			sums.delete();
		endfunction

		function int pending();
			return sums.size();
		endfunction

		function logic signed [SUM_W-1:0] widen(logic signed [COEF_W-1:0] c);
			return {c[COEF_W-1], c};
		endfunction

		function void push_sum(logic signed [SUM_W-1:0] c, logic [EXP_W-1:0] e);
			sum_term_t s;
			s.coef = c;
			s.expon = e;
			s.final_flag = 1'b0;
			s.empty_flag = 1'b0;
			s.lost_flag = lost;
			sums.push_back(s);
		endfunction

		function void note_beat(logic [1:0] o, term_t t);
			int a;
			int b;
			int n;
			logic signed [SUM_W-1:0] s;
			sum_term_t z;
			a = 0;
			b = 0;
			if (o == OP_LOAD_A) begin
				if (first_cnt < MAX_TERMS) begin
					first_buf[first_cnt] = t;
					first_cnt++;
				end else begin
					lost = 1'b1;
				end
				return;
			end
			if (o == OP_LOAD_B) begin
				if (second_cnt < MAX_TERMS) begin
					second_buf[second_cnt] = t;
					second_cnt++;
				end else begin
					lost = 1'b1;
				end
				return;
			end
			if (o != OP_RUN)
				return;
			n = sums.size();
			// only head terms are compared, order of the loads is not checked
			while (a < first_cnt && b < second_cnt) begin
				if (first_buf[a].expon == second_buf[b].expon) begin
					s = widen(first_buf[a].coef) + widen(second_buf[b].coef);
					if (s != 0)
						push_sum(s, first_buf[a].expon);
					a++;
					b++;
				end else if (first_buf[a].expon > second_buf[b].expon) begin
					push_sum(widen(first_buf[a].coef), first_buf[a].expon);
					a++;
				end else begin
					push_sum(widen(second_buf[b].coef), second_buf[b].expon);
					b++;
				end
			end
			for (; a < first_cnt; a++)
				push_sum(widen(first_buf[a].coef), first_buf[a].expon);
			for (; b < second_cnt; b++)
				push_sum(widen(second_buf[b].coef), second_buf[b].expon);
			if (sums.size() == n) begin
				push_sum('0, '0);
				z = sums.pop_back();
				z.empty_flag = 1'b1;
				sums.push_back(z);
			end
			z = sums.pop_back();
			z.final_flag = 1'b1;
			sums.push_back(z);
			first_cnt = 0;
			second_cnt = 0;
			lost = 1'b0;
		endfunction

		function bit check_term(logic signed [SUM_W-1:0] c, logic [EXP_W-1:0] e,
				logic fin, logic emp, logic lst, output string why);
			sum_term_t x;
			why = "";
			if (sums.size() == 0) begin
				why = $sformatf("result beat with nothing expected: coef %0d expon %0d",
					c, e);
				return 1'b0;
			end
			x = sums.pop_front();
			if (c !== x.coef)
				why = {why, $sformatf(" sum_coef %0d/%0d", c, x.coef)};
			if (e !== x.expon)
				why = {why, $sformatf(" sum_expon %0d/%0d", e, x.expon)};
			if (fin !== x.final_flag)
				why = {why, $sformatf(" final_term %b/%b", fin, x.final_flag)};
			if (emp !== x.empty_flag)
				why = {why, $sformatf(" no_terms %b/%b", emp, x.empty_flag)};
			if (lst !== x.lost_flag)
				why = {why, $sformatf(" lost_load %b/%b", lst, x.lost_flag)};
			if (why == "")
				return 1'b1;
			why = {"got/expected:", why};
			return 1'b0;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_LOAD_A;
	logic signed [COEF_W-1:0] term_coef = '0;
	logic [EXP_W-1:0] term_expon = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SUM_W-1:0] sum_coef;
	logic [EXP_W-1:0] sum_expon;
	logic final_term;
	logic no_terms;
	logic lost_load;

	poly_sum_board sb;
	beat_t plan[$];
	int err_count = 0;
	int items_sent = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	sparse_polynomial_add DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.term_coef  (term_coef),
		.term_expon (term_expon),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sum_coef   (sum_coef),
		.sum_expon  (sum_expon),
		.final_term (final_term),
		.no_terms   (no_terms),
		.lost_load  (lost_load)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(string msg);
		err_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void add_beat(logic [1:0] o, logic signed [COEF_W-1:0] c,
			logic [EXP_W-1:0] e);
		beat_t b;
		b.op = o;
		b.t.coef = c;
		b.t.expon = e;
		plan.push_back(b);
	endfunction

	// valid stays up into the next beat when no gap follows
	task automatic send_beat(beat_t b);
		int gap;
		in_valid <= 1'b1;
		op <= b.op;
		term_coef <= b.t.coef;
		term_expon <= b.t.expon;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(b.op, b.t);
		if (b.op != OP_IGNORED)
			items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_plan();
		while (plan.size() != 0)
			send_beat(plan.pop_front());
	endtask

	task automatic build_sequence(seq_kind_t kind);
		term_t qa[$];
		term_t qb[$];
		term_t t;
		int k;
		int prev;
		int extra;
		logic signed [COEF_W-1:0] c;
		if (kind == SEQ_NOISE) begin
			repeat ($urandom_range(1, 8))
				add_beat(2'($urandom), 16'($urandom), 10'($urandom));
			return;
		end
		if (kind == SEQ_NORMAL)
			k = $urandom_range(0, 7);
		else
			k = $urandom_range(20, 32);
		prev = ($urandom_range(0, 3) == 0) ? $urandom_range(k + 1, 64) : 1024;
		for (int i = 0; i < k; i++) begin
			t.expon = 10'($urandom_range(prev - 1, k - 1 - i));
			prev = t.expon;
			c = 16'($urandom);
			t.coef = c;
			case ($urandom_range(0, 2))
				0: qa.push_back(t);
				1: qb.push_back(t);
				default: begin
					qa.push_back(t);
					// shared exponent, half the time the sum cancels
					t.coef = $urandom_range(0, 1) ? -c : 16'($urandom);
					qb.push_back(t);
				end
			endcase
		end
		if (kind == SEQ_OVERFLOW) begin
			extra = $urandom_range(1, 3);
			if ($urandom_range(0, 1)) begin
				while (qa.size() < MAX_TERMS + extra) begin
					t.coef = 16'($urandom);
					t.expon = 10'($urandom);
					qa.push_back(t);
				end
			end else begin
				while (qb.size() < MAX_TERMS + extra) begin
					t.coef = 16'($urandom);
					t.expon = 10'($urandom);
					qb.push_back(t);
				end
			end
		end
		while (qa.size() != 0 || qb.size() != 0) begin
			if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1))) begin
				t = qa.pop_front();
				add_beat(OP_LOAD_A, t.coef, t.expon);
			end else begin
				t = qb.pop_front();
				add_beat(OP_LOAD_B, t.coef, t.expon);
			end
			if ($urandom_range(0, 19) == 0)
				add_beat(OP_IGNORED, 16'($urandom), 10'($urandom));
		end
		add_beat(OP_RUN, 16'($urandom), 10'($urandom));
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
						: $urandom_range(8, 30);
			end
		end
	end

	always @(posedge clk) begin
		string why;
		if (arst_n && out_valid && out_ready) begin
			if (!sb.check_term(sum_coef, sum_expon, final_term, no_terms, lost_load, why))
				report(why);
		end
	end

	initial begin
		int seq_idx;
		int r;
		seq_kind_t kind;
		sb = new();
		sb.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// run on empty buffers gives the empty-sum beat
		add_beat(OP_RUN, 16'sh1234, 10'd5);
		add_beat(OP_IGNORED, 16'sh7fff, 10'd1023);
		// extreme coefficients add to the extremes of the sum
		add_beat(OP_LOAD_A, 16'sh7fff, 10'd1023);
		add_beat(OP_LOAD_B, 16'sh7fff, 10'd1023);
		add_beat(OP_LOAD_A, 16'sh8000, 10'd0);
		add_beat(OP_LOAD_B, 16'sh8000, 10'd0);
		add_beat(OP_RUN, 16'sh0000, 10'd0);
		// cancelling terms leave an empty sum
		add_beat(OP_LOAD_A, 16'sd5, 10'd7);
		add_beat(OP_LOAD_B, -16'sd5, 10'd7);
		add_beat(OP_RUN, 16'sh8000, 10'd1023);
		// loads out of exponent order
		add_beat(OP_LOAD_A, 16'sd1, 10'd3);
		add_beat(OP_LOAD_A, 16'sd2, 10'd10);
		add_beat(OP_LOAD_B, 16'sd4, 10'd5);
		add_beat(OP_RUN, 16'sd0, 10'd0);
		// leftover copies from each side
		add_beat(OP_LOAD_A, -16'sd1, 10'd512);
		add_beat(OP_RUN, 16'sd0, 10'd0);
		add_beat(OP_LOAD_B, 16'sd100, 10'd600);
		add_beat(OP_LOAD_B, -16'sd3, 10'd1);
		add_beat(OP_IGNORED, 16'sh8000, 10'd0);
		add_beat(OP_LOAD_A, 16'sh7fff, 10'd600);
		add_beat(OP_RUN, 16'sd0, 10'd0);
		send_plan();

		seq_idx = 0;
		while (items_sent < 270) begin
			r = $urandom_range(0, 99);
			if (seq_idx == 0)
				kind = SEQ_OVERFLOW;
			else if (seq_idx == 2)
				kind = SEQ_LARGE;
			else if (r < 70)
				kind = SEQ_NORMAL;
			else if (r < 78)
				kind = SEQ_LARGE;
			else if (r < 85)
				kind = SEQ_OVERFLOW;
			else
				kind = SEQ_NOISE;
			quiet = (seq_idx == 2) || ($urandom_range(0, 4) == 0);
			build_sequence(kind);
			// long receiver hold-off while the sender keeps offering loads
			if (seq_idx == 2)
				hold_req = 1'b1;
			send_plan();
			if (seq_idx == 6) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			seq_idx++;
		end
		quiet = 1'b0;
		add_beat(OP_RUN, 16'sd0, 10'd0);
		send_plan();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (80) @(posedge clk);
		if (err_count == 0)
			$display("sparse_polynomial_add_tb: PASS");
		else
			$display("sparse_polynomial_add_tb: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("sparse_polynomial_add_tb: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/spa_pkg.sv
hdl/spa_term_mem.sv
hdl/spa_merge.sv
hdl/sparse_polynomial_add.sv
tb/sparse_polynomial_add_tb.sv
